// ===== rtl/ssd_pkg.sv =====
`timescale 1ns / 1ps
package ssd_pkg;

    localparam int CHIPS      = 16;
    localparam int IDX_W      = 4;
    localparam int NORM_W     = 16;
    localparam int SUM_W      = 20;
    localparam int TERM_W     = 23;
    localparam int SQ_W       = 45;
    localparam int ACC_W      = 48;
    localparam int DIST_W     = 17;
    localparam int METRIC_W   = 18;
    localparam int MARGIN_W   = 17;
    localparam int DIV_NUM_W  = 35;
    localparam int DIV_DEN_W  = 19;
    localparam int DIV_CNT_W  = 6;
    localparam int STEP_W     = 5;

    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 96;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MASKS_LOW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASKS_MID_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASKS_MID_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MASKS_HIGH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ENERGY     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RESIDUAL   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_MARGIN     = 3'd6;

    localparam logic [15:0] MAX_RESIDUAL_RST = 16'd32768;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM,
        S_SUM,
        S_ENERGY,
        S_DIST,
        S_MSTART,
        S_MARGIN,
        S_OUT
    } t_state;

endpackage

// ===== rtl/ssd_div.sv =====
`timescale 1ns / 1ps
module ssd_div
    import ssd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_done,
    output logic [DIV_NUM_W-1:0] o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W:0]   trial;

    // one restoring step: bring down the next numerator bit, try a subtract
    assign shifted = {r_rem, r_quo[DIV_NUM_W-1]};
    assign trial   = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= i_num;
        end else if (r_busy) begin
            if (!trial[DIV_DEN_W]) begin
                r_rem <= trial[DIV_DEN_W-1:0];
                r_quo <= {r_quo[DIV_NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[DIV_DEN_W-1:0];
                r_quo <= {r_quo[DIV_NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== rtl/ssd_sqacc.sv =====
`timescale 1ns / 1ps
module ssd_sqacc
    import ssd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clear,
    input  logic                     i_valid,
    input  logic signed [TERM_W-1:0] i_value,
    output logic [ACC_W-1:0]         o_acc
);

    logic signed [2*TERM_W-1:0] prod;
    logic [SQ_W-1:0]            r_sq;
    logic                       r_sq_vld;
    logic [ACC_W-1:0]           r_acc;

    assign prod = i_value * i_value;

    // register the square, then add it in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= 1'b0;
            r_acc    <= '0;
        end else if (i_clear) begin
            r_sq_vld <= 1'b0;
            r_acc    <= '0;
        end else begin
            r_sq_vld <= i_valid;
            if (r_sq_vld) begin
                r_acc <= r_acc + ACC_W'(r_sq);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq <= prod[SQ_W-1:0];
    end

    assign o_acc = r_acc;

endmodule

// ===== rtl/soft_symbol_demapper.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Beat contents
// s_axis    in         tdata: chip_luma[11:0] centre_luma[23:12] half_span[34:24]
//                      tuser: already_unreliable; tlast: last_chip
// m_axis    out        tdata: plane0..3_metric, symbol_margin; tuser: unreliable
// cfg       in         i_cfg_index selects register, i_cfg_data holds value
//
// Each chip is accepted, then normalized on the shared restoring divider.
// The last chip of a tile then runs a sum pass, an energy pass and 16 distance passes
// on the shared square-accumulate unit, the margin (a start state, then the divider)
// and the load of the output register.
// Reset is synchronous, active low; it clears control state and config registers.
// A result waits in the output register; a later tile stalls only at its own result.
module soft_symbol_demapper
    import ssd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // chip_luma, centre_luma, half_span
    input  logic                  s_axis_tuser,  // already_unreliable
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,  // plane0..3_metric, symbol_margin
    output logic                  m_axis_tuser,  // unreliable
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [CFG_DATA_W-1:0] r_masks [4];
    logic [16:0]           r_min_energy;
    logic [15:0]           r_max_residual;
    logic [16:0]           r_min_margin;

    logic signed [NORM_W-1:0] r_store [CHIPS];
    logic [IDX_W-1:0]  r_chip_idx;
    logic              r_sticky;
    logic [11:0]       r_centre;
    logic [10:0]       r_half;
    logic              r_neg;
    logic              r_last;

    logic [STEP_W-1:0]       r_k;
    logic [3:0]              r_sym;
    logic signed [SUM_W-1:0] r_sum;
    logic                    r_low_energy;
    logic [DIST_W-1:0]       r_b0, r_b1;
    logic [DIST_W-1:0]       r_zero [4];
    logic [DIST_W-1:0]       r_one [4];
    logic [MARGIN_W-1:0]     r_margin;

    logic                    r_out_valid;
    logic [M_TDATA_W-1:0]    r_out_data;
    logic                    r_out_unrel;

    logic accept;
    logic div_start, div_done;
    logic [DIV_NUM_W-1:0] div_num, div_quot;
    logic [DIV_DEN_W-1:0] div_den;
    logic sq_clear, sq_valid;
    logic [ACC_W-1:0] sq_acc;
    logic out_free;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 4; j++) begin
                r_masks[j] <= '0;
            end
            r_min_energy   <= '0;
            r_max_residual <= MAX_RESIDUAL_RST;
            r_min_margin   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MASKS_LOW:      r_masks[0] <= i_cfg_data;
                REG_MASKS_MID_LOW:  r_masks[1] <= i_cfg_data;
                REG_MASKS_MID_HIGH: r_masks[2] <= i_cfg_data;
                REG_MASKS_HIGH:     r_masks[3] <= i_cfg_data;
                REG_MIN_ENERGY:     r_min_energy <= i_cfg_data[16:0];
                REG_MAX_RESIDUAL:   r_max_residual <= i_cfg_data[15:0];
                REG_MIN_MARGIN:     r_min_margin <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // ---------------- input decode ----------------
    logic [11:0]        in_chip, in_centre, use_centre;
    logic [10:0]        in_half, use_half, half_nz;
    logic signed [12:0] diff;
    logic [11:0]        mag;
    logic [DIV_NUM_W-1:0] norm_num;

    assign in_chip    = s_axis_tdata[11:0];
    assign in_centre  = s_axis_tdata[23:12];
    assign in_half    = s_axis_tdata[34:24];
    assign use_centre = (r_chip_idx == '0) ? in_centre : r_centre;
    assign use_half   = (r_chip_idx == '0) ? in_half : r_half;
    assign half_nz    = (use_half == '0) ? 11'd1 : use_half;
    assign diff       = $signed({1'b0, in_chip}) - $signed({1'b0, use_centre});
    assign mag        = diff[12] ? 12'(-diff) : diff[11:0];
    assign norm_num   = DIV_NUM_W'({mag, 12'd0}) + DIV_NUM_W'(half_nz[10:1]);

    assign accept = s_axis_tvalid && s_axis_tready;

    // ---------------- shared term for energy and distance ----------------
    logic signed [NORM_W-1:0] rd_chip;
    logic signed [TERM_W-1:0] d_term, t_term;
    logic [CFG_DATA_W-1:0]    mask_word;
    logic                     mask_bit;

    assign rd_chip   = r_store[r_k[IDX_W-1:0]];
    assign d_term    = (TERM_W'(rd_chip) <<< 4) - TERM_W'(r_sum);
    assign mask_word = r_masks[r_sym[3:2]];
    assign mask_bit  = mask_word[{r_sym[1:0], r_k[IDX_W-1:0]}];
    assign t_term    = mask_bit ? d_term - TERM_W'(65536) : d_term + TERM_W'(65536);

    // ---------------- distance rounding and margin setup ----------------
    logic [ACC_W:0]        dist_round;
    logic [DIST_W-1:0]     sym_dist;
    logic [DIST_W:0]       den_raw, den;
    logic [DIST_W-1:0]     gap;

    assign dist_round = {1'b0, sq_acc} + (ACC_W+1)'(1 << 23);
    assign sym_dist = (dist_round[ACC_W:24] > (ACC_W-23)'(131071)) ? DIST_W'(131071)
                                                                   : dist_round[24+DIST_W-1:24];
    assign den_raw = {1'b0, r_b0} + {1'b0, r_b1};
    assign den     = (den_raw == '0) ? (DIST_W+1)'(1) : den_raw;
    assign gap     = r_b1 - r_b0;

    // ---------------- verdict and metrics ----------------
    logic unrel;
    logic signed [METRIC_W-1:0] metric [4];
    logic signed [METRIC_W-1:0] mdiff;
    logic [METRIC_W-1:0]        mabs;

    assign unrel = r_sticky || r_low_energy
                || ({r_b0, 2'b00} > 19'(r_max_residual))
                || (r_margin < r_min_margin);

    always_comb begin
        for (int p = 0; p < 4; p++) begin
            mdiff = $signed({1'b0, r_one[p]}) - $signed({1'b0, r_zero[p]});
            mabs  = mdiff[METRIC_W-1] ? METRIC_W'(-mdiff) : mdiff;
            mabs  = (mabs + 1'b1) >> 1;
            if (unrel) begin
                metric[p] = '0;
            end else if (mdiff[METRIC_W-1]) begin
                metric[p] = -$signed(mabs);
            end else begin
                metric[p] = $signed(mabs);
            end
        end
    end

    assign out_free = !r_out_valid || m_axis_tready;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (accept) n_state = S_NORM;
            S_NORM:   if (div_done) n_state = r_last ? S_SUM : S_IDLE;
            S_SUM:    if (r_k == STEP_W'(CHIPS - 1)) n_state = S_ENERGY;
            S_ENERGY: if (r_k == STEP_W'(CHIPS + 1)) n_state = S_DIST;
            S_DIST:   if (r_k == STEP_W'(CHIPS + 1) && r_sym == 4'd15) n_state = S_MSTART;
            S_MSTART: n_state = S_MARGIN;
            S_MARGIN: if (div_done) n_state = S_OUT;
            S_OUT:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        div_num       = norm_num;
        div_den       = DIV_DEN_W'(half_nz);
        sq_valid      = 1'b0;
        sq_clear      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                div_start     = s_axis_tvalid;
            end
            S_ENERGY, S_DIST: begin
                sq_valid = (r_k < STEP_W'(CHIPS));
                sq_clear = (r_k == STEP_W'(CHIPS + 1));
            end
            S_MSTART: begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'({gap, 17'd0}) + DIV_NUM_W'(den);
                div_den   = {den, 1'b0};
            end
            default: ;
        endcase
    end

    ssd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    ssd_sqacc u_sqacc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (sq_clear),
        .i_valid (sq_valid),
        .i_value (sq_valid ? ((r_state == S_ENERGY) ? d_term : t_term) : '0),
        .o_acc   (sq_acc)
    );

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chip_idx  <= '0;
            r_sticky    <= 1'b0;
            r_centre    <= '0;
            r_half      <= '0;
            r_k         <= '0;
            r_sym       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // load the result beat, or drop it once taken
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_k <= '0;
                    if (accept) begin
                        if (r_chip_idx == '0) begin
                            r_centre <= in_centre;
                            r_half   <= in_half;
                            r_sticky <= s_axis_tuser;
                        end else begin
                            r_sticky <= r_sticky | s_axis_tuser;
                        end
                    end
                end
                S_NORM: begin
                    if (div_done) begin
                        r_chip_idx <= r_last ? '0 : r_chip_idx + 1'b1;
                    end
                end
                S_SUM: begin
                    r_k <= (r_k == STEP_W'(CHIPS - 1)) ? '0 : r_k + 1'b1;
                end
                S_ENERGY: begin
                    r_k   <= (r_k == STEP_W'(CHIPS + 1)) ? '0 : r_k + 1'b1;
                    r_sym <= '0;
                end
                S_DIST: begin
                    if (r_k == STEP_W'(CHIPS + 1)) begin
                        r_k   <= '0;
                        r_sym <= r_sym + 1'b1;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_neg  <= diff[12];
                r_last <= s_axis_tlast;
                r_sum  <= '0;
            end
            S_NORM: begin
                // saturate the normalized chip and store it
                if (div_done) begin
                    if (r_neg) begin
                        r_store[r_chip_idx] <= (div_quot > DIV_NUM_W'(32768))
                            ? NORM_W'(-32768) : NORM_W'(-div_quot);
                    end else begin
                        r_store[r_chip_idx] <= (div_quot > DIV_NUM_W'(32767))
                            ? NORM_W'(32767) : NORM_W'(div_quot);
                    end
                end
            end
            S_SUM: begin
                r_sum <= r_sum + SUM_W'(rd_chip);
            end
            S_ENERGY: begin
                r_b0 <= '1;
                r_b1 <= '1;
                for (int p = 0; p < 4; p++) begin
                    r_zero[p] <= '1;
                    r_one[p]  <= '1;
                end
                if (r_k == STEP_W'(CHIPS + 1)) begin
                    r_low_energy <= ({1'b0, sq_acc} < (ACC_W+1)'({r_min_energy, 20'd0}));
                end
            end
            S_DIST: begin
                // keep best two and per-bit minimums
                if (r_k == STEP_W'(CHIPS + 1)) begin
                    if (sym_dist < r_b0) begin
                        r_b1 <= r_b0;
                        r_b0 <= sym_dist;
                    end else if (sym_dist < r_b1) begin
                        r_b1 <= sym_dist;
                    end
                    for (int p = 0; p < 4; p++) begin
                        if (r_sym[p]) begin
                            if (sym_dist < r_one[p]) r_one[p] <= sym_dist;
                        end else begin
                            if (sym_dist < r_zero[p]) r_zero[p] <= sym_dist;
                        end
                    end
                end
            end
            S_MARGIN: begin
                if (div_done) r_margin <= div_quot[MARGIN_W-1:0];
            end
            S_OUT: begin
                if (out_free) begin
                    r_out_data  <= {7'd0, r_margin, metric[3], metric[2],
                                    metric[1], metric[0]};
                    r_out_unrel <= unrel;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_unrel;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import ssd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 120;
    localparam int DRAIN_CYCLES   = 600;

    typedef struct {
        int  luma;
        int  centre;
        int  half;
        bit  flagged;
        bit  last;
    } t_chip;

    typedef struct {
        logic [3:0][METRIC_W-1:0] metric;
        logic [MARGIN_W-1:0]      margin;
        bit                       unrel;
    } t_symbol;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    soft_symbol_demapper u_top (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow of the block's registers and tile state
    logic [63:0] masks_shadow [4];
    longint      min_energy_sh, max_residual_sh, min_margin_sh;
    longint      norm_store [CHIPS];
    int          fill_index;
    bit          sticky_flag;
    int          latched_centre, latched_half;

    t_chip   chip_q [$];
    t_symbol symbol_q [$];
    t_chip   cur_chip;
    int      snd_idle, rcv_idle;
    int      errors, chips_sent, symbols_seen, flagged_seen, stall_cycles;

    function automatic longint normalize_chip(int luma, int centre, int half);
        longint diff, mag, h, q;
        diff = luma - centre;
        mag  = (diff < 0 ? -diff : diff) << 12;
        h    = (half == 0) ? 1 : half;
        q    = (mag + h / 2) / h;
        if (diff < 0)
            return (q > 32768) ? -32768 : -q;
        return (q > 32767) ? 32767 : q;
    endfunction

    function automatic longint halve_away(longint v);
        if (v >= 0)
            return (v + 1) >>> 1;
        return -((-v + 1) >>> 1);
    endfunction

    function automatic logic [15:0] codeword(int s);
        return 16'((masks_shadow[s >> 2] >> ((s & 3) * 16)) & 64'hFFFF);
    endfunction

    // advance the tile state by one chip, queue the decoded symbol on the last one
    function automatic void demap_chip(t_chip c);
        longint  total, energy, acc, q, b0, b1, den, margin, z, o, e, t;
        longint  centred [CHIPS];
        longint  sym_dist [16];
        logic [15:0] cw;
        bit      unrel;
        t_symbol r;
        if (fill_index == 0) begin
            latched_centre = c.centre;
            latched_half   = c.half;
            sticky_flag    = c.flagged;
        end else begin
            sticky_flag |= c.flagged;
        end
        norm_store[fill_index] = normalize_chip(c.luma, latched_centre, latched_half);
        if (!c.last) begin
            fill_index = (fill_index + 1) % CHIPS;
            return;
        end
        fill_index = 0;
        total  = 0;
        energy = 0;
        for (int i = 0; i < CHIPS; i++) total += norm_store[i];
        for (int i = 0; i < CHIPS; i++) begin
            centred[i] = 16 * norm_store[i] - total;
            energy += centred[i] * centred[i];
        end
        b0 = 64'h3FFFF;
        b1 = 64'h3FFFF;
        for (int s = 0; s < 16; s++) begin
            acc = 0;
            cw  = codeword(s);
            for (int i = 0; i < CHIPS; i++) begin
                e = cw[i] ? 65536 : -65536;
                t = centred[i] - e;
                acc += t * t;
            end
            q = (acc + (64'd1 << 23)) >> 24;
            sym_dist[s] = (q > 131071) ? 131071 : q;
            if (sym_dist[s] < b0) begin
                b1 = b0;
                b0 = sym_dist[s];
            end else if (sym_dist[s] < b1) begin
                b1 = sym_dist[s];
            end
        end
        den = b0 + b1;
        if (den == 0) den = 1;
        margin = (((b1 - b0) << 17) + den) / (2 * den);
        unrel = sticky_flag || (energy < (min_energy_sh << 20))
            || ((b0 << 2) > max_residual_sh) || (margin < min_margin_sh);
        for (int p = 0; p < 4; p++) begin
            z = 64'h3FFFF;
            o = 64'h3FFFF;
            for (int s = 0; s < 16; s++) begin
                if ((s >> p) & 1) begin
                    if (sym_dist[s] < o) o = sym_dist[s];
                end else begin
                    if (sym_dist[s] < z) z = sym_dist[s];
                end
            end
            r.metric[p] = unrel ? '0 : METRIC_W'(halve_away(o - z));
        end
        r.margin = MARGIN_W'(margin);
        r.unrel  = unrel;
        symbol_q.push_back(r);
    endfunction

    // drive chip beats; hold a beat until taken, predict on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                demap_chip(cur_chip);
                chips_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (chip_q.size() > 0 && $urandom_range(99) >= snd_idle) begin
                    cur_chip = chip_q.pop_front();
                    s_axis_tdata <= {5'd0, 11'(cur_chip.half), 12'(cur_chip.centre),
                                     12'(cur_chip.luma)};
                    s_axis_tuser  <= cur_chip.flagged;
                    s_axis_tlast  <= cur_chip.last;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // throttle the result side
    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= rcv_idle);
    end

    // check each result beat against the oldest predicted symbol
    always @(posedge i_clk) begin
        t_symbol x;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            symbols_seen++;
            if (m_axis_tuser) flagged_seen++;
            if (symbol_q.size() == 0) begin
                $error("result beat with no symbol pending");
                errors++;
            end else begin
                x = symbol_q.pop_front();
                for (int p = 0; p < 4; p++) begin
                    if (m_axis_tdata[p*METRIC_W +: METRIC_W] !== x.metric[p]) begin
                        $error("plane%0d_metric expected %0d got %0d", p,
                               $signed(x.metric[p]),
                               $signed(m_axis_tdata[p*METRIC_W +: METRIC_W]));
                        errors++;
                    end
                end
                if (m_axis_tdata[4*METRIC_W +: MARGIN_W] !== x.margin) begin
                    $error("symbol_margin expected %0d got %0d", x.margin,
                           m_axis_tdata[4*METRIC_W +: MARGIN_W]);
                    errors++;
                end
                if (m_axis_tuser !== x.unrel) begin
                    $error("unreliable expected %0d got %0d", x.unrel, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout with %0d symbols pending", symbol_q.size());
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_MASKS_LOW, REG_MASKS_MID_LOW, REG_MASKS_MID_HIGH, REG_MASKS_HIGH:
                masks_shadow[idx[1:0]] = data;
            REG_MIN_ENERGY:   min_energy_sh   = data & 64'h1FFFF;
            REG_MAX_RESIDUAL: max_residual_sh = data & 64'hFFFF;
            REG_MIN_MARGIN:   min_margin_sh   = data & 64'h1FFFF;
            default: ;
        endcase
    endtask

    task automatic write_all(logic [63:0] m0, logic [63:0] m1, logic [63:0] m2,
                             logic [63:0] m3, int energy, int residual, int marg);
        write_reg(REG_MASKS_LOW, m0);
        write_reg(REG_MASKS_MID_LOW, m1);
        write_reg(REG_MASKS_MID_HIGH, m2);
        write_reg(REG_MASKS_HIGH, m3);
        write_reg(REG_MIN_ENERGY, 64'(energy));
        write_reg(REG_MAX_RESIDUAL, 64'(residual));
        write_reg(REG_MIN_MARGIN, 64'(marg));
    endtask

    // hold until every chip is taken and every symbol is back, then let the block settle
    task automatic wait_idle();
        wait (chip_q.size() == 0 && !s_axis_tvalid && symbol_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic void push_chip(int luma, int centre, int half, bit flagged, bit last);
        t_chip c;
        c.luma    = luma;
        c.centre  = centre;
        c.half    = half;
        c.flagged = flagged;
        c.last    = last;
        chip_q.push_back(c);
    endfunction

    function automatic int clamp_luma(int v);
        return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
    endfunction

    // one random tile: mostly noisy codewords, some short, wrapped or raw tiles
    function automatic int push_tile();
        int kind, len, sym, centre, half, noise, luma;
        bit close, raw;
        logic [15:0] cw;
        kind   = $urandom_range(99);
        sym    = $urandom_range(15);
        cw     = codeword(sym);
        centre = $urandom_range(800, 3300);
        half   = $urandom_range(512, 2040);
        noise  = $urandom_range(0, 3) == 0 ? $urandom_range(0, 900) : $urandom_range(0, 200);
        len    = (kind >= 75 && kind < 85) ? $urandom_range(1, 15) : CHIPS;
        close  = !(kind >= 92 && kind < 96);
        raw    = (kind >= 85 && kind < 92) || kind >= 96;
        if (kind >= 96) begin
            centre = $urandom_range(4095);
            half   = $urandom_range(2047);
        end
        for (int i = 0; i < len; i++) begin
            if (raw)
                luma = $urandom_range(4095);
            else
                luma = clamp_luma(centre + (cw[i] ? half : -half)
                                  + $urandom_range(0, 2 * noise) - noise);
            push_chip(luma, i == 0 ? centre : $urandom_range(4095),
                      i == 0 ? half : $urandom_range(2047),
                      $urandom_range(99) < 4, close && i == len - 1);
        end
        return len;
    endfunction

    task automatic run_random(int target);
        int n;
        n = 0;
        while (n < target) n += push_tile();
        wait_idle();
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    initial begin
        logic [63:0] shared;
        errors = 0;
        chips_sent = 0;
        symbols_seen = 0;
        flagged_seen = 0;
        stall_cycles = 0;
        fill_index = 0;
        sticky_flag = 0;
        latched_centre = 0;
        latched_half = 0;
        foreach (masks_shadow[k]) masks_shadow[k] = '0;
        foreach (norm_store[k]) norm_store[k] = 0;
        min_energy_sh = 0;
        max_residual_sh = MAX_RESIDUAL_RST;
        min_margin_sh = 0;
        snd_idle = 34;
        rcv_idle = 67;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: all masks zero, so every distance ties
        // full first tile at the luma extremes, fills the whole store
        for (int i = 0; i < CHIPS; i++)
            push_chip(i[0] ? 4095 : 0, 2048, 512, 1'b0, i == CHIPS - 1);
        // short tile with zero half span, flagged upstream
        push_chip(4095, 0, 0, 1'b1, 1'b0);
        push_chip(0, 4095, 2047, 1'b0, 1'b0);
        push_chip(4095, 0, 0, 1'b0, 1'b0);
        push_chip(0, 0, 0, 1'b0, 1'b1);
        // short tile at the top of centre and half span
        for (int i = 0; i < 5; i++)
            push_chip(i[0] ? 0 : 4095, 4095, 2047, 1'b0, i == 4);
        wait_idle();

        // lenient thresholds, random masks; unused index must do nothing
        write_all(rand64(), rand64(), rand64(), rand64(), 0, 32768, 0);
        write_reg(REG_UNUSED, '1);
        run_random(300);

        // strict thresholds: most symbols come back unreliable
        write_all(rand64(), rand64(), rand64(), rand64(), 65536, 0, 65536);
        run_random(150);

        // moderate thresholds with duplicated masks for equal distances
        snd_idle = 67;
        rcv_idle = 34;
        shared = rand64();
        write_all(shared, rand64(), shared, rand64(), $urandom_range(0, 20000),
                  $urandom_range(6000, 32768), $urandom_range(0, 16000));
        run_random(400);

        // no idling on either side
        snd_idle = 0;
        rcv_idle = 0;
        write_all(rand64(), rand64(), rand64(), rand64(), $urandom_range(0, 8000),
                  $urandom_range(10000, 32768), $urandom_range(0, 8000));
        run_random(400);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d chips over four threshold settings, checked %0d symbols",
                 chips_sent, symbols_seen);
        $display("%0d symbols flagged unreliable; short, wrapped and raw tiles included",
                 flagged_seen);
        if (errors == 0 && symbol_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
